// ===== rtl/pmsq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsq_pkg
// Shared types and constants for the priority mode switch qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsq_pkg;

  // Width of the hold counters (4 to 32)
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of the hold thresholds in the register file
  localparam int unsigned THR_W       = 16;
  // Common width for count vs threshold compares
  localparam int unsigned CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  // APB side
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned IDX_W       = 2;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [IDX_W-1:0] {
    REG_MODE_HOLD   = 2'd0,
    REG_ESTOP_HOLD  = 2'd1,
    REG_BUTTON_HOLD = 2'd2
  } reg_idx_e;

  // Register reset values
  localparam logic [THR_W-1:0] MODE_HOLD_RST   = THR_W'(150);
  localparam logic [THR_W-1:0] ESTOP_HOLD_RST  = THR_W'(7);
  localparam logic [THR_W-1:0] BUTTON_HOLD_RST = THR_W'(15);

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_ESTOP   = 3'd1,
    MODE_AUTO    = 3'd2,
    MODE_REMOTE  = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Thresholds handed from the register file to the qualifiers
  typedef struct packed {
    logic [THR_W-1:0] mode_hold;
    logic [THR_W-1:0] estop_hold;
    logic [THR_W-1:0] button_hold;
  } cfg_t;

  // Saturating increment
  function automatic count_t bump(input count_t c);
    bump = (c == '1) ? c : c + count_t'(1);
  endfunction

  // count >= threshold, both zero-extended to a common width
  function automatic logic reached(input count_t c, input logic [THR_W-1:0] thr);
    reached = (CMP_W'(c) >= CMP_W'(thr));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pmsq_if.sv =====
// ----------------------------------------------------------------------------
// pmsq_req_if / pmsq_rsp_if
// Valid/ready channels carrying pin samples in and qualified state out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmsq_req_if;
  logic valid;
  logic ready;
  logic estop_level;
  logic auto_switch_level;
  logic remote_switch_level;
  logic button_level;

  modport source (
    output valid, estop_level, auto_switch_level, remote_switch_level, button_level,
    input  ready
  );
  modport sink (
    input  valid, estop_level, auto_switch_level, remote_switch_level, button_level,
    output ready
  );
endinterface

interface pmsq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       button_flag;
  logic       button_toggled;

  modport source (
    output valid, mode, button_flag, button_toggled,
    input  ready
  );
  modport sink (
    input  valid, mode, button_flag, button_toggled,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pmsq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pmsq_cfg_regs
// APB register file holding the three hold thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsq_cfg_regs (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [pmsq_pkg::ADDR_W-1:0] paddr,
  input  wire  [pmsq_pkg::DATA_W-1:0] pwdata,
  output logic [pmsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output pmsq_pkg::cfg_t              cfg_o
);
  import pmsq_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[IDX_W+1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_hold   <= MODE_HOLD_RST;
      cfg_q.estop_hold  <= ESTOP_HOLD_RST;
      cfg_q.button_hold <= BUTTON_HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE_HOLD:   cfg_q.mode_hold   <= pwdata[THR_W-1:0];
        REG_ESTOP_HOLD:  cfg_q.estop_hold  <= pwdata[THR_W-1:0];
        REG_BUTTON_HOLD: cfg_q.button_hold <= pwdata[THR_W-1:0];
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE_HOLD:   prdata = DATA_W'(cfg_q.mode_hold);
      REG_ESTOP_HOLD:  prdata = DATA_W'(cfg_q.estop_hold);
      REG_BUTTON_HOLD: prdata = DATA_W'(cfg_q.button_hold);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/pmsq_mode_qual.sv =====
// ----------------------------------------------------------------------------
// pmsq_mode_qual
// Priority qualifier for estop / auto / remote / idle with hold counters.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsq_mode_qual (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  wire                  estop_i,
  input  wire                  auto_sel_i,
  input  wire                  remote_sel_i,
  input  wire [pmsq_pkg::THR_W-1:0] mode_hold_i,
  input  wire [pmsq_pkg::THR_W-1:0] estop_hold_i,
  output pmsq_pkg::mode_e      mode_next_o
);
  import pmsq_pkg::*;

  count_t estop_cnt_q, estop_cnt_d;
  count_t auto_cnt_q, auto_cnt_d;
  count_t remote_cnt_q, remote_cnt_d;
  count_t idle_cnt_q, idle_cnt_d;
  mode_e  mode_q, mode_d;
  logic   qual;
  mode_e  winner;

  always_comb begin
    estop_cnt_d  = estop_cnt_q;
    auto_cnt_d   = auto_cnt_q;
    remote_cnt_d = remote_cnt_q;
    idle_cnt_d   = idle_cnt_q;
    mode_d       = mode_q;
    qual         = 1'b0;
    winner       = MODE_STOPPED;

    if (estop_i) begin
      estop_cnt_d = bump(estop_cnt_q);
      qual        = reached(estop_cnt_d, estop_hold_i);
      winner      = MODE_ESTOP;
    end else if (auto_sel_i) begin
      auto_cnt_d  = bump(auto_cnt_q);
      qual        = reached(auto_cnt_d, mode_hold_i);
      winner      = MODE_AUTO;
    end else if (remote_sel_i) begin
      remote_cnt_d = bump(remote_cnt_q);
      qual         = reached(remote_cnt_d, mode_hold_i);
      winner       = MODE_REMOTE;
    end else begin
      idle_cnt_d  = bump(idle_cnt_q);
      qual        = reached(idle_cnt_d, mode_hold_i);
    end

    if (qual) begin
      mode_d       = winner;
      auto_cnt_d   = '0;
      remote_cnt_d = '0;
      idle_cnt_d   = '0;
      // estop counter keeps saturating while estop wins
      if (winner != MODE_ESTOP) begin
        estop_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_cnt_q  <= '0;
      auto_cnt_q   <= '0;
      remote_cnt_q <= '0;
      idle_cnt_q   <= '0;
      mode_q       <= MODE_NONE;
    end else if (step_i) begin
      estop_cnt_q  <= estop_cnt_d;
      auto_cnt_q   <= auto_cnt_d;
      remote_cnt_q <= remote_cnt_d;
      idle_cnt_q   <= idle_cnt_d;
      mode_q       <= mode_d;
    end
  end

  assign mode_next_o = mode_d;

  // once a mode is latched, it never falls back to "none"
  a_mode_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_NONE) |=> (mode_q != MODE_NONE))
    else $error("mode returned to none");

  // a mode change always clears the non-estop counters
  a_qual_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_d != mode_q)) |=> (auto_cnt_q == '0 && remote_cnt_q == '0
                                        && idle_cnt_q == '0))
    else $error("counters not cleared on mode change");

endmodule

`default_nettype wire

// ===== rtl/pmsq_button_qual.sv =====
// ----------------------------------------------------------------------------
// pmsq_button_qual
// Press-and-hold toggle for the push button, re-armed on release.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsq_button_qual (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       step_i,
  input  wire                       pressed_i,
  input  wire [pmsq_pkg::THR_W-1:0] hold_i,
  output logic                      flag_next_o,
  output logic                      toggled_o
);
  import pmsq_pkg::*;

  count_t cnt_q, cnt_d;
  logic   armed_off_q, armed_off_d;
  logic   latch_q, latch_d;
  count_t cnt_inc;

  assign cnt_inc = bump(cnt_q);

  always_comb begin
    cnt_d       = cnt_q;
    armed_off_d = armed_off_q;
    latch_d     = latch_q;
    toggled_o   = 1'b0;
    if (pressed_i) begin
      if (!armed_off_q) begin
        cnt_d = cnt_inc;
        if (reached(cnt_inc, hold_i)) begin
          latch_d     = ~latch_q;
          armed_off_d = 1'b1;
          cnt_d       = '0;
          toggled_o   = 1'b1;
        end
      end
    end else begin
      armed_off_d = 1'b0;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      armed_off_q <= 1'b0;
      latch_q     <= 1'b0;
    end else if (step_i) begin
      cnt_q       <= cnt_d;
      armed_off_q <= armed_off_d;
      latch_q     <= latch_d;
    end
  end

  assign flag_next_o = latch_d;

endmodule

`default_nettype wire

// ===== rtl/priority_mode_switch_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// priority_mode_switch_qualifier_unit
// Debounces estop, two mode switches and a push button with hold counters.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  -------   ---  ------------------  -----------------------------------------
//  req_i     in   valid/ready         estop, auto/remote switch, button levels
//  rsp_o     out  valid/ready         mode, button_flag, button_toggled
//  APB       in   psel/penable/pready three 16-bit hold thresholds
//
//  One request per clock, sustained while rsp_o is not stalled. A request
//  is captured in the input register, and its result is then written to the
//  output register once that is free. The counters update as it is loaded.
//  Reset (rst_ni low, async) clears all counters, mode and button state and
//  loads the default thresholds. A stalled output holds the input register,
//  which drops req_i.ready only when both stages are full.
//
`default_nettype none

module priority_mode_switch_qualifier_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // config
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [pmsq_pkg::ADDR_W-1:0] paddr,
  input  wire  [pmsq_pkg::DATA_W-1:0] pwdata,
  output logic [pmsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // channels
  pmsq_req_if.sink                    req_i,
  pmsq_rsp_if.source                  rsp_o
);
  import pmsq_pkg::*;

  cfg_t  cfg;

  // input stage
  logic  in_vld_q;
  logic  estop_q, auto_lvl_q, remote_lvl_q, button_lvl_q;
  // output stage
  logic  out_vld_q;
  mode_e out_mode_q;
  logic  out_flag_q, out_tgl_q;

  logic  out_free, step, accept;
  mode_e mode_next;
  logic  flag_next, toggled;

  // advance when the output register is empty or being drained
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign step        = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;
  assign accept      = req_i.valid && req_i.ready;

  pmsq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // switch levels are active low, estop active high
  pmsq_mode_qual u_mode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .estop_i      (estop_q),
    .auto_sel_i   (!auto_lvl_q),
    .remote_sel_i (!remote_lvl_q),
    .mode_hold_i  (cfg.mode_hold),
    .estop_hold_i (cfg.estop_hold),
    .mode_next_o  (mode_next)
  );

  pmsq_button_qual u_button (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pressed_i   (!button_lvl_q),
    .hold_i      (cfg.button_hold),
    .flag_next_o (flag_next),
    .toggled_o   (toggled)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      estop_q      <= req_i.estop_level;
      auto_lvl_q   <= req_i.auto_switch_level;
      remote_lvl_q <= req_i.remote_switch_level;
      button_lvl_q <= req_i.button_level;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_mode_q <= mode_next;
      out_flag_q <= flag_next;
      out_tgl_q  <= toggled;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.mode           = out_mode_q;
  assign rsp_o.button_flag    = out_flag_q;
  assign rsp_o.button_toggled = out_tgl_q;

  // every processed request produces a result next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed request produced no result");

  // an empty input stage never backpressures
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> req_i.ready)
    else $error("ready low with empty input stage");

  // delivered mode stays in the legal range
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_mode_q <= MODE_STOPPED))
    else $error("illegal mode code delivered");

  // a toggle result flips the flag relative to the previous processed request
  a_toggle_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && toggled) |-> (flag_next != u_button.latch_q))
    else $error("toggle without flag change");

endmodule

`default_nettype wire
